/* rtl/dtsg_pkg.sv */
// ----------------------------------------------------------------------------
// dtsg_pkg
// Shared widths, register indexes, word types and the quarter-wave sine table
// of the dual tone sine generator.
// ----------------------------------------------------------------------------
package dtsg_pkg;

   localparam int PHASE_BITS     = 32;
   localparam int SINE_ADDR_BITS = 10;
   localparam int SAMPLE_BITS    = 16;
   localparam int GAIN_BITS      = 16;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 3;

   localparam int QUAD_BITS = SINE_ADDR_BITS - 2;
   localparam int QLEN      = 1 << QUAD_BITS;
   localparam int MAG_BITS  = SAMPLE_BITS - 1;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_PHASE_STEP_A = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PHASE_STEP_B = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GAIN_A       = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GAIN_B       = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_OUTPUT_MODE  = 3'd4;

   localparam logic [GAIN_BITS-1:0] GAIN_A_RESET = 16'd26214;
   localparam logic [GAIN_BITS-1:0] GAIN_B_RESET = 16'd9830;

   localparam logic MODE_STEREO = 1'b0;
   localparam logic MODE_TEST   = 1'b1;

   typedef struct packed {
      logic [PHASE_BITS-1:0] phase_step_a;
      logic [PHASE_BITS-1:0] phase_step_b;
      logic [GAIN_BITS-1:0]  gain_a;
      logic [GAIN_BITS-1:0]  gain_b;
      logic                  output_mode;
   } cfg_type;

   // table addresses of both tones for one frame
   typedef struct packed {
      logic [SINE_ADDR_BITS-1:0] addr_a;
      logic [SINE_ADDR_BITS-1:0] addr_b;
   } frame_word_type;

   typedef logic [QLEN:0][MAG_BITS-1:0] sine_rom_type;

   // first quadrant magnitudes, Q30 odd polynomial rounded half up
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0]  u;
      logic [63:0]  u2;
      logic [63:0]  p;
      logic [63:0]  s;
      logic [63:0]  v;
      logic [63:0]  top;
      top = (64'd1 << MAG_BITS) - 64'd1;
      for (int i = 0; i <= QLEN; i++) begin
         u  = 64'(i) << (30 - QUAD_BITS);
         u2 = (u * u) >> 30;
         p  = 64'd3864;
         p  = 64'd172272 - ((p * u2) >> 30);
         p  = 64'd5026995 - ((p * u2) >> 30);
         p  = 64'd85569306 - ((p * u2) >> 30);
         p  = 64'd693598668 - ((p * u2) >> 30);
         p  = 64'd1686629713 - ((p * u2) >> 30);
         s  = (p * u) >> 30;
         v  = (s + (64'd1 << (30 - SAMPLE_BITS))) >> (31 - SAMPLE_BITS);
         if (v > top) begin
            v = top;
         end
         rom[i] = v[MAG_BITS-1:0];
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage

/* rtl/dtsg_front.sv */
// ----------------------------------------------------------------------------
// dtsg_front
// Accepts frame ticks, applies restart and advances both phase accumulators,
// handing the table addresses of each frame to the queue.
// ----------------------------------------------------------------------------
module dtsg_front import dtsg_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  logic           req_valid,
   input  logic           req_restart,
   input  logic           queue_full,
   output logic           push,
   output frame_word_type push_word
);

   logic [PHASE_BITS-1:0] acc_a_ff, acc_a_in;
   logic [PHASE_BITS-1:0] acc_b_ff, acc_b_in;
   logic [PHASE_BITS-1:0] phase_a;
   logic [PHASE_BITS-1:0] phase_b;

   assign push = req_valid & ~queue_full;

   // restart zeroes before the frame is produced
   assign phase_a = req_restart ? '0 : acc_a_ff;
   assign phase_b = req_restart ? '0 : acc_b_ff;

   assign push_word.addr_a = phase_a[PHASE_BITS-1 -: SINE_ADDR_BITS];
   assign push_word.addr_b = phase_b[PHASE_BITS-1 -: SINE_ADDR_BITS];

   always_comb begin
      acc_a_in = acc_a_ff;
      acc_b_in = acc_b_ff;
      if (push) begin
         acc_a_in = phase_a + cfg.phase_step_a;
         acc_b_in = phase_b + cfg.phase_step_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_a_ff <= '0;
         acc_b_ff <= '0;
      end else begin
         acc_a_ff <= acc_a_in;
         acc_b_ff <= acc_b_in;
      end
   end

endmodule

/* rtl/dtsg_queue.sv */
// ----------------------------------------------------------------------------
// dtsg_queue
// Two-entry queue of frame words between the front and the back.
// ----------------------------------------------------------------------------
module dtsg_queue import dtsg_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  frame_word_type push_word,
   input  logic           pop,
   output logic           full,
   output logic           empty,
   output frame_word_type head_word
);

   frame_word_type mem_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign empty     = (count_ff == 2'd0);
   assign head_word = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/dtsg_back.sv */
// ----------------------------------------------------------------------------
// dtsg_back
// Three-stage sample pipeline: sine lookup, gain multiply, round and mix
// into the result register.
// ----------------------------------------------------------------------------
module dtsg_back import dtsg_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  logic                          queue_empty,
   input  frame_word_type                head_word,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_left_sample,
   output logic signed [SAMPLE_BITS-1:0] rsp_right_sample
);

   localparam int PROD_BITS  = SAMPLE_BITS + GAIN_BITS + 1;
   localparam int SCALE_BITS = PROD_BITS - 15;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {MAG_BITS{1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {MAG_BITS{1'b0}}};

   logic advance;

   logic                          v1_ff, v1_in;
   logic                          v2_ff, v2_in;
   logic                          v3_ff, v3_in;
   logic signed [SAMPLE_BITS-1:0] sine_a_ff, sine_a_in;
   logic signed [SAMPLE_BITS-1:0] sine_b_ff, sine_b_in;
   logic signed [PROD_BITS-1:0]   prod_a_ff, prod_a_in;
   logic signed [PROD_BITS-1:0]   prod_b_ff, prod_b_in;
   logic signed [SAMPLE_BITS-1:0] left_ff, left_in;
   logic signed [SAMPLE_BITS-1:0] right_ff, right_in;

   logic signed [SCALE_BITS-1:0]  scaled_a;
   logic signed [SCALE_BITS-1:0]  scaled_b;
   logic signed [SAMPLE_BITS-1:0] tone_a;
   logic signed [SAMPLE_BITS-1:0] tone_b;
   logic signed [SAMPLE_BITS:0]   mix_sum;
   logic signed [GAIN_BITS:0]     gain_b_sel;

   function automatic logic signed [SAMPLE_BITS-1:0] sine_of(
      input logic [SINE_ADDR_BITS-1:0] addr
   );
      logic [1:0]          quad;
      logic [QUAD_BITS-1:0] r;
      logic [QUAD_BITS:0]  frac;
      logic [MAG_BITS-1:0] mag;
      quad = addr[SINE_ADDR_BITS-1 -: 2];
      r    = addr[QUAD_BITS-1:0];
      // falling quadrants read the table backward
      frac = quad[0] ? ((QUAD_BITS+1)'(QLEN) - {1'b0, r}) : {1'b0, r};
      mag  = SINE_ROM[frac];
      return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] sat_scaled(
      input logic signed [SCALE_BITS-1:0] v
   );
      if (v > SCALE_BITS'(SAMPLE_MAX)) begin
         return SAMPLE_MAX;
      end else if (v < SCALE_BITS'(SAMPLE_MIN)) begin
         return SAMPLE_MIN;
      end
      return v[SAMPLE_BITS-1:0];
   endfunction

   // the whole pipeline moves as one when the result register can take a word
   assign advance = ~v3_ff | ~rsp_stall;
   assign pop     = advance & ~queue_empty;

   assign gain_b_sel = (cfg.output_mode == MODE_TEST) ? $signed({1'b0, cfg.gain_b})
                                                      : $signed({1'b0, cfg.gain_a});

   // round half up, floor shift by 15
   assign scaled_a = SCALE_BITS'((prod_a_ff + PROD_BITS'(16384)) >>> 15);
   assign scaled_b = SCALE_BITS'((prod_b_ff + PROD_BITS'(16384)) >>> 15);
   assign tone_a   = sat_scaled(scaled_a);
   assign tone_b   = sat_scaled(scaled_b);
   assign mix_sum  = (SAMPLE_BITS+1)'(tone_a) + (SAMPLE_BITS+1)'(tone_b);

   always_comb begin
      v1_in     = v1_ff;
      v2_in     = v2_ff;
      v3_in     = v3_ff;
      sine_a_in = sine_a_ff;
      sine_b_in = sine_b_ff;
      prod_a_in = prod_a_ff;
      prod_b_in = prod_b_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      if (advance) begin
         v1_in     = ~queue_empty;
         v2_in     = v1_ff;
         v3_in     = v2_ff;
         sine_a_in = sine_of(head_word.addr_a);
         sine_b_in = sine_of(head_word.addr_b);
         prod_a_in = PROD_BITS'(sine_a_ff * $signed({1'b0, cfg.gain_a}));
         prod_b_in = PROD_BITS'(sine_b_ff * gain_b_sel);
         right_in  = tone_b;
         if (cfg.output_mode == MODE_TEST) begin
            if (mix_sum > (SAMPLE_BITS+1)'(SAMPLE_MAX)) begin
               left_in = SAMPLE_MAX;
            end else if (mix_sum < (SAMPLE_BITS+1)'(SAMPLE_MIN)) begin
               left_in = SAMPLE_MIN;
            end else begin
               left_in = mix_sum[SAMPLE_BITS-1:0];
            end
         end else begin
            left_in = tone_a;
         end
      end
   end

   always_ff @(posedge clock) begin
      sine_a_ff <= sine_a_in;
      sine_b_ff <= sine_b_in;
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
      left_ff   <= left_in;
      right_ff  <= right_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   assign rsp_valid        = v3_ff;
   assign rsp_left_sample  = left_ff;
   assign rsp_right_sample = right_ff;

endmodule

/* rtl/dual_tone_sine_generator.sv */
// ----------------------------------------------------------------------------
// dual_tone_sine_generator
// Two-tone DDS: one left/right sample word per frame tick, with stereo and
// test-signal mixing modes.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_restart
//   rsp      out        rsp_valid/rsp_stall  rsp_left_sample, rsp_right_sample
//   csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One word per cycle sustained while rsp is not stalled; a tick's samples pass the
// queue, then the lookup, multiply and round/mix stages behind it.
// Synchronous reset clears phases, queue and pipeline valids; registers reload
// their reset values.
// A stall on rsp freezes the back pipeline; the two-entry queue then fills and
// raises req_stall. csr writes are always taken.
// ----------------------------------------------------------------------------
module dual_tone_sine_generator import dtsg_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_restart,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_left_sample,
   output logic signed [SAMPLE_BITS-1:0] rsp_right_sample,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata
);

   cfg_type        cfg_ff, cfg_in;
   logic           queue_full;
   logic           queue_empty;
   logic           push;
   logic           pop;
   frame_word_type push_word;
   frame_word_type head_word;

   assign csr_ready = 1'b1;
   assign req_stall = queue_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_PHASE_STEP_A: cfg_in.phase_step_a = csr_wdata[PHASE_BITS-1:0];
            REG_PHASE_STEP_B: cfg_in.phase_step_b = csr_wdata[PHASE_BITS-1:0];
            REG_GAIN_A:       cfg_in.gain_a       = csr_wdata[GAIN_BITS-1:0];
            REG_GAIN_B:       cfg_in.gain_b       = csr_wdata[GAIN_BITS-1:0];
            REG_OUTPUT_MODE:  cfg_in.output_mode  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_step_a <= '0;
         cfg_ff.phase_step_b <= '0;
         cfg_ff.gain_a       <= GAIN_A_RESET;
         cfg_ff.gain_b       <= GAIN_B_RESET;
         cfg_ff.output_mode  <= MODE_STEREO;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dtsg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .queue_full  (queue_full),
      .push        (push),
      .push_word   (push_word)
   );

   dtsg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .full      (queue_full),
      .empty     (queue_empty),
      .head_word (head_word)
   );

   dtsg_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .queue_empty      (queue_empty),
      .head_word        (head_word),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_left_sample  (rsp_left_sample),
      .rsp_right_sample (rsp_right_sample)
   );

endmodule

/* bench/tb_dual_tone_sine_generator.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dual_tone_sine_generator
// Self-checking bench for the two-tone DDS. Frame ticks are sent through the
// req channel and sample words are taken from the rsp channel, with random
// gaps and stalls on both sides. A local model of the phase accumulators,
// quarter-wave sine, gain rounding and mixing predicts each word, and every
// accepted word is compared against the oldest prediction. Settings are
// loaded over the csr channel only while the datapath is empty.
// ----------------------------------------------------------------------------
module tb_dual_tone_sine_generator;
   import dtsg_pkg::*;

   localparam int CLOCK_HALF   = 6;
   localparam int RESET_CYCLES = 10;
   localparam int DRAIN_CYCLES = 8;
   localparam int REPORT_LIMIT = 10;

   localparam logic [CSR_INDEX_BITS-1:0] REG_UNUSED_FIRST = REG_OUTPUT_MODE + 3'd1;

   localparam logic [PHASE_BITS-1:0] QUARTER_TURN       = 32'h4000_0000;
   localparam logic [PHASE_BITS-1:0] HALF_TURN          = 32'h8000_0000;
   localparam logic [PHASE_BITS-1:0] THREE_QUARTER_TURN = 32'hC000_0000;

   localparam longint SAMPLE_HI = (longint'(1) <<< MAG_BITS) - 1;
   localparam longint SAMPLE_LO = -SAMPLE_HI - 1;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left;
      logic signed [SAMPLE_BITS-1:0] right;
   } stereo_word_type;

   logic                          clock       = 1'b0;
   logic                          reset       = 1'b1;
   logic                          req_valid   = 1'b0;
   logic                          req_stall;
   logic                          req_restart = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall   = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_left_sample;
   logic signed [SAMPLE_BITS-1:0] rsp_right_sample;
   logic                          csr_valid   = 1'b0;
   logic                          csr_ready;
   logic [CSR_INDEX_BITS-1:0]     csr_index   = '0;
   logic [CSR_DATA_BITS-1:0]      csr_wdata   = '0;

   // local copy of the block's settings and phases
   cfg_type               shadow_cfg;
   logic [PHASE_BITS-1:0] tone_phase_a;
   logic [PHASE_BITS-1:0] tone_phase_b;

   stereo_word_type expected_frames[$];
   int              fault_count = 0;
   int              stall_hold  = 0;
   bit              req_gaps_on = 1'b1;
   bit              rsp_holds_on = 1'b1;

   dual_tone_sine_generator uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_left_sample  (rsp_left_sample),
      .rsp_right_sample (rsp_right_sample),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // mostly short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // taylor coefficients of sin(pi/2 u) in q30, highest order first
   function automatic logic [63:0] sine_coef(input int k);
      case (k)
         0: return 64'd3864;
         1: return 64'd172272;
         2: return 64'd5026995;
         3: return 64'd85569306;
         4: return 64'd693598668;
         default: return 64'd1686629713;
      endcase
   endfunction

   function automatic longint quarter_wave_mag(input int frac);
      logic [63:0] u;
      logic [63:0] u2;
      logic [63:0] p;
      logic [63:0] mag;
      u  = 64'(frac) << (30 - QUAD_BITS);
      u2 = (u * u) >> 30;
      p  = sine_coef(0);
      for (int k = 1; k < 6; k++) begin
         p = sine_coef(k) - ((p * u2) >> 30);
      end
      mag = (((p * u) >> 30) + (64'd1 << (30 - SAMPLE_BITS))) >> (31 - SAMPLE_BITS);
      if (mag > 64'(SAMPLE_HI)) begin
         mag = 64'(SAMPLE_HI);
      end
      return longint'(mag);
   endfunction

   function automatic longint tone_level(input logic [PHASE_BITS-1:0] phase);
      logic [SINE_ADDR_BITS-1:0] addr;
      logic [1:0]                quad;
      int                        frac;
      longint                    mag;
      addr = phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
      quad = addr[SINE_ADDR_BITS-1 -: 2];
      frac = int'(addr[QUAD_BITS-1:0]);
      // odd quadrants run the table backwards
      if (quad[0]) begin
         frac = QLEN - frac;
      end
      mag = quarter_wave_mag(frac);
      return quad[1] ? -mag : mag;
   endfunction

   function automatic longint clip_sample(input longint v);
      if (v > SAMPLE_HI) return SAMPLE_HI;
      if (v < SAMPLE_LO) return SAMPLE_LO;
      return v;
   endfunction

   function automatic longint apply_gain(input longint level, input logic [GAIN_BITS-1:0] gain);
      return clip_sample((level * longint'({1'b0, gain}) + 64'sd16384) >>> 15);
   endfunction

   function automatic stereo_word_type predict_frame(input logic restart);
      stereo_word_type w;
      longint          la;
      longint          lb;
      longint          left;
      longint          right;
      if (restart) begin
         tone_phase_a = '0;
         tone_phase_b = '0;
      end
      la = tone_level(tone_phase_a);
      lb = tone_level(tone_phase_b);
      if (shadow_cfg.output_mode == MODE_TEST) begin
         right = apply_gain(lb, shadow_cfg.gain_b);
         left  = clip_sample(apply_gain(la, shadow_cfg.gain_a) + right);
      end else begin
         left  = apply_gain(la, shadow_cfg.gain_a);
         right = apply_gain(lb, shadow_cfg.gain_a);
      end
      tone_phase_a = tone_phase_a + shadow_cfg.phase_step_a;
      tone_phase_b = tone_phase_b + shadow_cfg.phase_step_b;
      w.left  = left[SAMPLE_BITS-1:0];
      w.right = right[SAMPLE_BITS-1:0];
      return w;
   endfunction

   function automatic void apply_setting(input logic [CSR_INDEX_BITS-1:0] index,
                                         input logic [CSR_DATA_BITS-1:0] data);
      case (index)
         REG_PHASE_STEP_A: shadow_cfg.phase_step_a = data[PHASE_BITS-1:0];
         REG_PHASE_STEP_B: shadow_cfg.phase_step_b = data[PHASE_BITS-1:0];
         REG_GAIN_A:       shadow_cfg.gain_a       = data[GAIN_BITS-1:0];
         REG_GAIN_B:       shadow_cfg.gain_b       = data[GAIN_BITS-1:0];
         REG_OUTPUT_MODE:  shadow_cfg.output_mode  = data[0];
         default: ;
      endcase
   endfunction

   task automatic send_tick(input logic restart);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
      expected_frames.push_back(predict_frame(restart));
   endtask

   // stop sending and let every outstanding word come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      apply_setting(index, data);
   endtask

   task automatic load_settings(input logic [CSR_DATA_BITS-1:0] step_a,
                                input logic [CSR_DATA_BITS-1:0] step_b,
                                input logic [CSR_DATA_BITS-1:0] gain_a,
                                input logic [CSR_DATA_BITS-1:0] gain_b,
                                input logic [CSR_DATA_BITS-1:0] mode,
                                input bit stray);
      wait_idle();
      csr_write(REG_PHASE_STEP_A, step_a);
      csr_write(REG_PHASE_STEP_B, step_b);
      csr_write(REG_GAIN_A, gain_a);
      csr_write(REG_GAIN_B, gain_b);
      csr_write(REG_OUTPUT_MODE, mode);
      // unused indexes must leave everything alone
      if (stray) begin
         for (int i = int'(REG_UNUSED_FIRST); i < (1 << CSR_INDEX_BITS); i++) begin
            csr_write(CSR_INDEX_BITS'(i), $urandom());
         end
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [CSR_DATA_BITS-1:0] pick_step();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return $urandom_range(1, 32'h00FF_FFFF);
         default: return $urandom();
      endcase
   endfunction

   // upper bits are junk the block has to drop
   function automatic logic [CSR_DATA_BITS-1:0] pick_gain_word();
      logic [CSR_DATA_BITS-1:0] upper;
      logic [GAIN_BITS-1:0]     g;
      upper = $urandom() & 32'hFFFF_0000;
      case ($urandom_range(0, 5))
         0: g = '0;
         1: g = 16'd32768;
         2: g = '1;
         3: g = GAIN_BITS'($urandom_range(0, 32768));
         default: g = GAIN_BITS'($urandom_range(0, 65535));
      endcase
      return upper | 32'(g);
   endfunction

   task automatic load_random_settings(input bit stray);
      load_settings(pick_step(), pick_step(), pick_gain_word(), pick_gain_word(),
                    $urandom(), stray);
   endtask

   task automatic test_reset_state();
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
   endtask

   task automatic test_quarter_turns();
      load_settings(QUARTER_TURN, HALF_TURN, 32'd32768, 32'd0, 32'(MODE_STEREO), 1'b0);
      send_tick(1'b1);
      repeat (4) send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
   endtask

   task automatic test_saturation();
      load_settings(QUARTER_TURN, QUARTER_TURN, 32'hFFFF_FFFF, 32'h0000_FFFF,
                    32'(MODE_TEST), 1'b0);
      send_tick(1'b1);
      repeat (4) send_tick(1'b0);
   endtask

   task automatic test_wrap_and_ignored_regs();
      load_settings(32'hFFFF_FFFF, THREE_QUARTER_TURN, 32'h0001_8000, 32'd32768,
                    32'hFFFF_FFFE, 1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
   endtask

   task automatic test_random_streams();
      for (int ph = 0; ph < 6; ph++) begin
         load_random_settings(ph % 2 == 1);
         repeat (100) send_tick($urandom_range(0, 31) == 0);
      end
   endtask

   task automatic test_quiet_stream();
      load_random_settings(1'b0);
      req_gaps_on  = 1'b0;
      rsp_holds_on = 1'b0;
      repeat (100) send_tick($urandom_range(0, 15) == 0);
      req_gaps_on  = 1'b1;
      rsp_holds_on = 1'b1;
   endtask

   task automatic test_drain_pause();
      load_random_settings(1'b0);
      repeat (40) send_tick($urandom_range(0, 31) == 0);
      wait_idle();
      repeat (40) send_tick($urandom_range(0, 31) == 0);
   endtask

   // result side: check the accepted word, then pick the next stall
   always @(posedge clock) begin : rsp_side
      stereo_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_frames.size() == 0) begin
            if (fault_count < REPORT_LIMIT) begin
               $display("%0t: unexpected word left=%0d right=%0d", $time,
                        rsp_left_sample, rsp_right_sample);
            end
            fault_count++;
         end else begin
            want = expected_frames.pop_front();
            if (rsp_left_sample !== want.left || rsp_right_sample !== want.right) begin
               if (fault_count < REPORT_LIMIT) begin
                  $display("%0t: mismatch left exp %0d got %0d, right exp %0d got %0d",
                           $time, want.left, rsp_left_sample, want.right,
                           rsp_right_sample);
               end
               fault_count++;
            end
         end
      end
      if (!rsp_holds_on) begin
         rsp_stall  <= 1'b0;
         stall_hold = 0;
      end else if (stall_hold != 0) begin
         stall_hold--;
      end else if (!rsp_stall && $urandom_range(0, 3) == 0) begin
         rsp_stall  <= 1'b1;
         stall_hold = pick_gap();
      end else begin
         rsp_stall  <= 1'b0;
         stall_hold = $urandom_range(0, 8);
      end
   end

   initial begin
      shadow_cfg.phase_step_a = '0;
      shadow_cfg.phase_step_b = '0;
      shadow_cfg.gain_a       = GAIN_A_RESET;
      shadow_cfg.gain_b       = GAIN_B_RESET;
      shadow_cfg.output_mode  = MODE_STEREO;
      tone_phase_a            = '0;
      tone_phase_b            = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_quarter_turns();
      test_saturation();
      test_wrap_and_ignored_regs();
      test_random_streams();
      test_quiet_stream();
      test_drain_pause();
      wait_idle();

      if (fault_count == 0 && expected_frames.size() == 0) begin
         $display("dual_tone_sine_generator verification clean");
      end else begin
         $display("dual_tone_sine_generator verification failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("dual_tone_sine_generator verification failed");
      $finish;
   end

endmodule

/* files.f */
rtl/dtsg_pkg.sv
rtl/dtsg_front.sv
rtl/dtsg_queue.sv
rtl/dtsg_back.sv
rtl/dual_tone_sine_generator.sv
bench/tb_dual_tone_sine_generator.sv
